@@ src/owfa_pkg.sv @@
// ----------------------------------------------------------------------------
// owfa_pkg
// Shared widths, constants and controller/datapath interface types for the
// overwrite ring FIFO with slot average.
// ----------------------------------------------------------------------------
`default_nettype none

package owfa_pkg;

    // Store geometry
    localparam int MAX_SLOTS = 16;
    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int SIZE_W    = $clog2(MAX_SLOTS + 1);
    localparam int MIN_SIZE  = 2;

    // Arithmetic widths
    localparam int BYTE_W     = 8;
    localparam int SUM_W      = 12;
    localparam int FRAC_W     = 8;
    localparam int DIVIDEND_W = SUM_W + FRAC_W;
    localparam int AVG_W      = 16;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int REM_W      = $clog2(MAX_SLOTS);

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic cfg_write;
        logic sweep_start;
        logic sweep_step;
        logic item_load;
        logic upd;
        logic div_start;
        logic out_load;
    } owfa_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic sweep_done;
        logic div_done;
    } owfa_sts_t;

endpackage

`default_nettype wire

@@ src/overwrite_ring_fifo_with_average_unit.sv @@
// ----------------------------------------------------------------------------
// overwrite_ring_fifo_with_average_unit
// Byte ring FIFO that overwrites its oldest entry when full and reports the
// Q8.8 mean of all ring slots with every result.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | moves
//  ---------+-----------------------------------------+--------------------------
//  config   | cfg_valid, cfg_ready, cfg_ring_size     | ring size write
//  input    | s_valid, s_ready, s_command, s_data_in  | insert or delete item
//  result   | m_valid, m_ready, m_data_out,           | one result per item
//           | m_was_empty, m_overwrote, m_average_q8  |
//
//  An item goes from acceptance to a loaded result through one slot read,
//  one update, one divider start, the bit-serial divider for the average
//  and one output load; the block then returns to idle for the next item.
//  A size write starts a sum sweep over the ring, during which no item is
//  accepted. Reset clears store valid bits, indices and sum at once.
//  A new item is accepted while an earlier result waits; the output load
//  stalls until that earlier result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module overwrite_ring_fifo_with_average_unit import owfa_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [4:0]        cfg_ring_size,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_command,
    input  wire logic [BYTE_W-1:0] s_data_in,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [BYTE_W-1:0]      m_data_out,
    output logic                   m_was_empty,
    output logic                   m_overwrote,
    output logic [AVG_W-1:0]       m_average_q8
);

    owfa_cmd_t cmd;
    owfa_sts_t sts;

    owfa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    owfa_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_ring_size (cfg_ring_size),
        .s_command     (s_command),
        .s_data_in     (s_data_in),
        .m_data_out    (m_data_out),
        .m_was_empty   (m_was_empty),
        .m_overwrote   (m_overwrote),
        .m_average_q8  (m_average_q8)
    );

endmodule

`default_nettype wire

@@ src/owfa_div.sv @@
// ----------------------------------------------------------------------------
// owfa_div
// Restoring divider, one quotient bit per cycle, for the scaled slot sum
// divided by the effective ring size.
// ----------------------------------------------------------------------------
`default_nettype none

module owfa_div import owfa_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [SIZE_W-1:0]     divisor,
    output logic                       done,
    output logic [AVG_W-1:0]           quot
);

    logic                  busy_reg, busy_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] q_reg, q_next;
    logic [REM_W-1:0]      r_reg, r_next;
    logic [SIZE_W-1:0]     d_reg, d_next;
    logic [REM_W:0]        trial;
    logic                  last;

    assign trial = {r_reg, q_reg[DIVIDEND_W-1]};
    assign last  = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign done  = busy_reg && last;
    assign quot  = q_reg[AVG_W-1:0];

    // Load operands on start, then shift in one quotient bit per cycle
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end else if (busy_reg) begin
            if ({1'b0, trial} >= {1'b0, d_reg}) begin
                r_next = REM_W'({1'b0, trial} - {1'b0, d_reg});
                q_next = {q_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                r_next = trial[REM_W-1:0];
                q_next = {q_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (last) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

endmodule

`default_nettype wire

@@ src/owfa_datapath.sv @@
// ----------------------------------------------------------------------------
// owfa_datapath
// Slot store, ring indices, running slot sum, size register, result
// register and the average divider.
// ----------------------------------------------------------------------------
`default_nettype none

module owfa_datapath import owfa_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire owfa_cmd_t         cmd,
    output owfa_sts_t              sts,
    input  wire logic [4:0]        cfg_ring_size,
    input  wire logic              s_command,
    input  wire logic [BYTE_W-1:0] s_data_in,
    output logic [BYTE_W-1:0]      m_data_out,
    output logic                   m_was_empty,
    output logic                   m_overwrote,
    output logic [AVG_W-1:0]       m_average_q8
);

    // Slot store with per-entry valid bits; an unwritten slot reads zero
    logic [BYTE_W-1:0]    mem [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] vld_reg;
    logic [BYTE_W-1:0]    rd_data_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic                 mem_we;

    logic [4:0]           size_reg;
    logic [SIZE_W-1:0]    n_eff;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [IDX_W-1:0]     tail_reg, tail_next;
    logic                 empty_reg, empty_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [SIZE_W-1:0]    sweep_cnt_reg, sweep_cnt_next;
    logic                 acc_reg, acc_next;
    logic                 sweep_rd;

    logic                 item_cmd_reg;
    logic [BYTE_W-1:0]    item_data_reg;
    logic [IDX_W-1:0]     ins_addr;
    logic [IDX_W-1:0]     item_addr;

    logic [BYTE_W-1:0]    res_dout_reg, res_dout_next;
    logic                 res_we_reg, res_we_next;
    logic                 res_ow_reg, res_ow_next;

    logic                 div_done;
    logic [AVG_W-1:0]     div_quot;

    function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] x,
                                             input logic [SIZE_W-1:0] n);
        logic [SIZE_W:0] x1;
        x1 = {{(SIZE_W + 1 - IDX_W){1'b0}}, x} + 1'b1;
        return (x1 >= {1'b0, n}) ? '0 : x1[IDX_W-1:0];
    endfunction

    // Clamp the ring size to the supported range
    always_comb begin
        if (size_reg < 5'(MIN_SIZE)) begin
            n_eff = SIZE_W'(MIN_SIZE);
        end else if (size_reg > 5'(MAX_SLOTS)) begin
            n_eff = SIZE_W'(MAX_SLOTS);
        end else begin
            n_eff = SIZE_W'(size_reg);
        end
    end

    // Pick the read address: sweep counter or the slot the item touches
    assign ins_addr  = empty_reg ? '0 : adv(tail_reg, n_eff);
    assign item_addr = (item_cmd_reg == CMD_INSERT) ? ins_addr : head_reg;
    assign sweep_rd  = cmd.sweep_step && (sweep_cnt_reg < n_eff);
    assign rd_addr   = sweep_rd ? sweep_cnt_reg[IDX_W-1:0] : item_addr;
    assign mem_we    = cmd.upd && (item_cmd_reg == CMD_INSERT);

    always_ff @(posedge aclk) begin
        rd_data_reg <= vld_reg[rd_addr] ? mem[rd_addr] : '0;
        if (mem_we) begin
            mem[ins_addr] <= item_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (mem_we) begin
            vld_reg[ins_addr] <= 1'b1;
        end
    end

    // Ring state, running sum and sweep
    always_comb begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        empty_next     = empty_reg;
        sum_next       = sum_reg;
        sweep_cnt_next = sweep_cnt_reg;
        acc_next       = 1'b0;
        res_dout_next  = res_dout_reg;
        res_we_next    = res_we_reg;
        res_ow_next    = res_ow_reg;

        if (cmd.sweep_start) begin
            sum_next       = '0;
            sweep_cnt_next = '0;
        end else begin
            // Accumulate the slot read in the previous sweep cycle
            if (acc_reg) begin
                sum_next = sum_reg + SUM_W'(rd_data_reg);
            end
            if (sweep_rd) begin
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                acc_next       = 1'b1;
            end
        end

        if (cmd.upd) begin
            res_dout_next = '0;
            res_we_next   = 1'b0;
            res_ow_next   = 1'b0;
            if (item_cmd_reg == CMD_INSERT) begin
                if (empty_reg) begin
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b0;
                end else begin
                    if (adv(tail_reg, n_eff) == head_reg) begin
                        head_next   = adv(head_reg, n_eff);
                        res_ow_next = 1'b1;
                    end
                    tail_next = adv(tail_reg, n_eff);
                end
                // Swap the old slot value for the new one in the sum
                sum_next = sum_reg - SUM_W'(rd_data_reg) + SUM_W'(item_data_reg);
            end else begin
                if (empty_reg) begin
                    res_we_next = 1'b1;
                end else begin
                    res_dout_next = rd_data_reg;
                    if (head_reg != tail_reg) begin
                        head_next = adv(head_reg, n_eff);
                    end else begin
                        empty_next = 1'b1;
                        head_next  = '0;
                        tail_next  = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg      <= 5'(MAX_SLOTS);
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            sum_reg       <= '0;
            sweep_cnt_reg <= '0;
            acc_reg       <= 1'b0;
        end else begin
            if (cmd.cfg_write) begin
                size_reg <= cfg_ring_size;
            end
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            sum_reg       <= sum_next;
            sweep_cnt_reg <= sweep_cnt_next;
            acc_reg       <= acc_next;
        end
    end

    // Hold the accepted item and the step results
    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            item_cmd_reg  <= s_command;
            item_data_reg <= s_data_in;
        end
        res_dout_reg <= res_dout_next;
        res_we_reg   <= res_we_next;
        res_ow_reg   <= res_ow_next;
    end

    owfa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend ({sum_reg, {FRAC_W{1'b0}}}),
        .divisor  (n_eff),
        .done     (div_done),
        .quot     (div_quot)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_out   <= res_dout_reg;
            m_was_empty  <= res_we_reg;
            m_overwrote  <= res_ow_reg;
            m_average_q8 <= div_quot;
        end
    end

    assign sts.sweep_done = (sweep_cnt_reg == n_eff) && !acc_reg;
    assign sts.div_done   = div_done;

endmodule

`default_nettype wire

@@ src/owfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// owfa_ctrl
// Sequencer for configuration sweeps and item steps, plus the output
// valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module owfa_ctrl import owfa_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    output owfa_cmd_t      cmd,
    input  wire owfa_sts_t sts
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SWEEP  = 7'b0000010,
        S_READ   = 7'b0000100,
        S_UPDATE = 7'b0001000,
        S_START  = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign cfg_ready = (state_reg == S_IDLE);
    assign s_ready   = (state_reg == S_IDLE) && !cfg_valid;
    assign m_valid   = out_valid_reg;

    // Step through sweep or item phases
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (cfg_valid) begin
                    cmd.cfg_write   = 1'b1;
                    cmd.sweep_start = 1'b1;
                    state_next      = S_SWEEP;
                end else if (s_valid) begin
                    cmd.item_load = 1'b1;
                    state_next    = S_READ;
                end
            end
            S_SWEEP: begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_done) begin
                    state_next = S_IDLE;
                end
            end
            S_READ: begin
                state_next = S_UPDATE;
            end
            S_UPDATE: begin
                cmd.upd    = 1'b1;
                state_next = S_START;
            end
            S_START: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV: begin
                if (sts.div_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result until it is taken
    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ test/overwrite_ring_fifo_with_average_unit_test.sv @@
// ----------------------------------------------------------------------------
// overwrite_ring_fifo_with_average_unit_test
// Self-checking bench for the overwrite ring FIFO with slot average. Drives
// insert and delete items over valid/ready, predicts data_out, the empty and
// overwrite flags and the Q8.8 slot mean in a local ring model, and compares
// every result in order. Covers ring sizes from 0 to 31 (clamped ones too),
// resizing with data held, long result backpressure and random idling.
// ----------------------------------------------------------------------------
`default_nettype none

module overwrite_ring_fifo_with_average_unit_test;
    import owfa_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int MAX_GAP       = 18;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 122;
    localparam int BURST_ITEMS   = 60;

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic              was_empty;
        logic              overwrote;
        logic [AVG_W-1:0]  average_q8;
    } ring_result_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [4:0]        cfg_ring_size;
    logic              s_valid;
    logic              s_ready;
    logic              s_command;
    logic [BYTE_W-1:0] s_data_in;
    logic              m_valid;
    logic              m_ready;
    logic [BYTE_W-1:0] m_data_out;
    logic              m_was_empty;
    logic              m_overwrote;
    logic [AVG_W-1:0]  m_average_q8;

    // Local ring model
    logic [BYTE_W-1:0] ring_slots [MAX_SLOTS];
    int                ring_head;
    int                ring_tail;
    bit                ring_is_empty;
    logic [4:0]        ring_size_reg;

    ring_result_t pending_ring_results [$];

    int  send_max_gap;
    int  recv_max_gap;
    bit  hold_request;
    int  fail_count;
    int  items_sent;
    int  inserts_sent;
    int  deletes_sent;
    int  overwrites_seen;
    int  empty_deletes_seen;
    int  results_checked;
    int  size_writes;

    overwrite_ring_fifo_with_average_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_ring_size (cfg_ring_size),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_data_in     (s_data_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_out    (m_data_out),
        .m_was_empty   (m_was_empty),
        .m_overwrote   (m_overwrote),
        .m_average_q8  (m_average_q8)
    );

    // Free-running clock
    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // Advance a ring index, wrapping at the active size
    function automatic int next_index(int idx, int n);
        return (idx + 1 >= n) ? 0 : idx + 1;
    endfunction

    // Apply one item to the ring model and return the result it produces
    function automatic ring_result_t predict_ring_result(logic cmd, logic [BYTE_W-1:0] data);
        ring_result_t res;
        int n;
        int sum;
        res = '0;
        n = ring_size_reg;
        if (n < MIN_SIZE) n = MIN_SIZE;
        if (n > MAX_SLOTS) n = MAX_SLOTS;
        if (cmd == CMD_INSERT) begin
            if (ring_is_empty) begin
                ring_head = 0;
                ring_tail = 0;
                ring_is_empty = 1'b0;
            end else begin
                // full ring: drop the oldest byte
                if (next_index(ring_tail, n) == ring_head) begin
                    ring_head = next_index(ring_head, n);
                    res.overwrote = 1'b1;
                end
                ring_tail = next_index(ring_tail, n);
            end
            ring_slots[ring_tail] = data;
        end else begin
            if (ring_is_empty) begin
                res.was_empty = 1'b1;
            end else begin
                res.data_out = ring_slots[ring_head];
                if (ring_head != ring_tail) begin
                    ring_head = next_index(ring_head, n);
                end else begin
                    ring_is_empty = 1'b1;
                    ring_head = 0;
                    ring_tail = 0;
                end
            end
        end
        // Mean over every active slot, stale bytes included
        sum = 0;
        for (int i = 0; i < n; i++) sum += ring_slots[i];
        res.average_q8 = AVG_W'((sum << FRAC_W) / n);
        return res;
    endfunction

    // Offer one item after a random gap and record its expected result
    task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] data);
        int gap;
        ring_result_t res;
        gap = (send_max_gap > 0) ? $urandom_range(0, send_max_gap) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_data_in <= data;
        do @(posedge aclk); while (!s_ready);
        res = predict_ring_result(cmd, data);
        pending_ring_results.push_back(res);
        items_sent++;
        if (cmd == CMD_INSERT) inserts_sent++;
        else deletes_sent++;
        if (res.overwrote) overwrites_seen++;
        if (res.was_empty) empty_deletes_seen++;
    endtask

    // Random insert or delete, with byte extremes mixed in
    task automatic send_random_item(input int insert_pct);
        logic cmd;
        logic [BYTE_W-1:0] data;
        cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_DELETE;
        case ($urandom_range(0, 7))
            0: data = 8'h00;
            1: data = 8'hFF;
            default: data = BYTE_W'($urandom_range(0, 255));
        endcase
        send_item(cmd, data);
    endtask

    // Stop offering items and hold until every expected result has come
    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_ring_results.size() != 0) @(posedge aclk);
    endtask

    // Write the ring size once the block is idle
    task automatic write_ring_size(input logic [4:0] value);
        wait_results_drained();
        @(negedge aclk);
        cfg_valid     <= 1'b1;
        cfg_ring_size <= value;
        do @(posedge aclk); while (!cfg_ready);
        ring_size_reg = value;
        size_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Empty deletes, ordering and byte extremes at the reset size
    task automatic test_empty_and_order();
        send_item(CMD_DELETE, 8'hFF);
        send_item(CMD_INSERT, 8'hFF);
        send_item(CMD_INSERT, 8'h00);
        send_item(CMD_INSERT, 8'h5A);
        send_item(CMD_DELETE, 8'h00);
        send_item(CMD_DELETE, 8'hFF);
        send_item(CMD_DELETE, 8'h00);
        send_item(CMD_DELETE, 8'h00);
    endtask

    // Overwrite of the oldest byte at the smallest ring
    task automatic test_overwrite_min_ring();
        write_ring_size(5'd2);
        send_item(CMD_INSERT, 8'h11);
        send_item(CMD_INSERT, 8'h22);
        send_item(CMD_INSERT, 8'h33);
        send_item(CMD_INSERT, 8'h44);
        send_item(CMD_DELETE, 8'h00);
        send_item(CMD_DELETE, 8'h00);
        send_item(CMD_DELETE, 8'h00);
    endtask

    // Shrink the ring while the tail sits beyond the new size
    task automatic test_resize_with_data();
        write_ring_size(5'd16);
        send_item(CMD_INSERT, 8'hA1);
        send_item(CMD_INSERT, 8'hA2);
        send_item(CMD_INSERT, 8'hA3);
        send_item(CMD_INSERT, 8'hA4);
        send_item(CMD_INSERT, 8'hA5);
        write_ring_size(5'd3);
        send_item(CMD_INSERT, 8'hB6);
        send_item(CMD_DELETE, 8'h00);
        send_item(CMD_DELETE, 8'h00);
    endtask

    // Stall the result side for a long stretch while items keep coming
    task automatic test_result_backpressure();
        send_max_gap = 0;
        hold_request = 1'b1;
        for (int i = 0; i < BURST_ITEMS; i++) send_random_item(70);
        wait_results_drained();
        send_max_gap = MAX_GAP;
    endtask

    // Random traffic over several ring sizes and idling patterns
    task automatic test_random_traffic();
        logic [4:0] sizes [PHASES];
        int insert_pct;
        sizes = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd5, 5'd1,
                  5'd17, 5'd9, 5'd3, 5'd16, 5'd0, 5'd12};
        for (int p = 0; p < PHASES; p++) begin
            write_ring_size((p >= 8 && p[0]) ? 5'($urandom_range(0, 31)) : sizes[p]);
            case (p % 4)
                0: begin send_max_gap = 0;       recv_max_gap = 0;       end
                1: begin send_max_gap = MAX_GAP; recv_max_gap = MAX_GAP; end
                2: begin send_max_gap = MAX_GAP; recv_max_gap = 0;       end
                default: begin send_max_gap = 0; recv_max_gap = MAX_GAP; end
            endcase
            case (p % 3)
                0: insert_pct = 50;
                1: insert_pct = 80;
                default: insert_pct = 30;
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) send_random_item(insert_pct);
        end
        send_max_gap = MAX_GAP;
        recv_max_gap = MAX_GAP;
    endtask

    // Result receiver: random ready gaps, or one long hold on request
    initial begin
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end else begin
                gap = (recv_max_gap > 0) ? $urandom_range(0, recv_max_gap) : 0;
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        ring_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_ring_results.size() == 0) begin
                $error("result with none expected: data_out %0d average_q8 %0d",
                       m_data_out, m_average_q8);
                fail_count++;
            end else begin
                want = pending_ring_results.pop_front();
                results_checked++;
                if (m_data_out !== want.data_out) begin
                    $error("data_out: expected %0d, actual %0d", want.data_out, m_data_out);
                    fail_count++;
                end
                if (m_was_empty !== want.was_empty) begin
                    $error("was_empty: expected %0d, actual %0d", want.was_empty, m_was_empty);
                    fail_count++;
                end
                if (m_overwrote !== want.overwrote) begin
                    $error("overwrote: expected %0d, actual %0d", want.overwrote, m_overwrote);
                    fail_count++;
                end
                if (m_average_q8 !== want.average_q8) begin
                    $error("average_q8: expected %0d, actual %0d",
                           want.average_q8, m_average_q8);
                    fail_count++;
                end
            end
        end
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("overwrite_ring_fifo_with_average_unit verification failed");
        $finish;
    end

    // Test sequence
    initial begin
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_ring_size = '0;
        s_valid       = 1'b0;
        s_command     = CMD_INSERT;
        s_data_in     = '0;
        for (int i = 0; i < MAX_SLOTS; i++) ring_slots[i] = '0;
        ring_head     = 0;
        ring_tail     = 0;
        ring_is_empty = 1'b1;
        ring_size_reg = 5'd16;
        send_max_gap  = MAX_GAP;
        recv_max_gap  = MAX_GAP;
        hold_request  = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_and_order();
        test_overwrite_min_ring();
        test_resize_with_data();
        test_result_backpressure();
        test_random_traffic();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Ran %0d items (%0d inserts, %0d deletes) across %0d ring size writes",
                 items_sent, inserts_sent, deletes_sent, size_writes);
        $display("Checked %0d results: %0d overwrites, %0d deletes on an empty ring",
                 results_checked, overwrites_seen, empty_deletes_seen);
        if (fail_count == 0) begin
            $display("overwrite_ring_fifo_with_average_unit verification clean");
        end else begin
            $display("overwrite_ring_fifo_with_average_unit verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
